// ----- rtl/core/ssr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ssr_pkg;

  // Width of a result count held by the output buffer (covers up to 15 bytes)
  localparam int CNT_W = 4;

  // Configuration register indexes
  localparam logic [1:0] REG_PATTERN_BYTES      = 2'd0;
  localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd1;
  localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  // Input beat
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } ssr_in_t;

  // Result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last;
  } ssr_out_t;

  // Burst description handed to the output buffer
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             has_byte;
    logic             last;
  } ssr_load_t;

endpackage

`default_nettype wire

// ----- rtl/core/ssr_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssr_cell (
  input  wire logic       clk,
  input  wire logic [7:0] pat_byte,
  input  wire logic       active,
  input  wire logic       wr,
  input  wire logic       shift,
  input  wire logic [7:0] in_byte,
  input  wire logic [7:0] next_in,
  output logic      [7:0] cur,
  output logic            hit
);

  logic [7:0] data;

  // Window byte as seen after this beat's write, before any shift
  assign cur = wr ? in_byte : data;

  // Compare against the pattern byte; unused positions always agree
  assign hit = !active || (cur == pat_byte);

  // Take the neighbor's byte on a shift, else load the incoming byte on a write
  always_ff @(posedge clk) begin
    if (shift) begin
      data <= next_in;
    end else if (wr) begin
      data <= in_byte;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ssr_burst.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssr_burst #(
  parameter int BYTES = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire ssr_pkg::ssr_load_t    load_ctl,
  input  wire logic [8*BYTES-1:0]    load_data,
  output logic                       ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output ssr_pkg::ssr_out_t          out_data
);

  logic [8*BYTES-1:0]        buffer;
  logic [ssr_pkg::CNT_W-1:0] count;
  logic                      has_byte;
  logic                      last;

  // Accept a new burst once the current one is gone or leaves this cycle
  assign ready = (count == '0) ||
                 ((count == ssr_pkg::CNT_W'(1)) && out_ready);

  // Present the head byte
  assign out_valid         = (count != '0);
  assign out_data.out_byte = buffer[7:0];
  assign out_data.has_byte = has_byte;
  assign out_data.last     = last && (count == ssr_pkg::CNT_W'(1));

  // Count of bytes still to send
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= load_ctl.count;
    end else if (out_valid && out_ready) begin
      count <= count - ssr_pkg::CNT_W'(1);
    end
  end

  // Load or advance the byte buffer
  always_ff @(posedge clk) begin
    if (load) begin
      buffer   <= load_data;
      has_byte <= load_ctl.has_byte;
      last     <= load_ctl.last;
    end else if (out_valid && out_ready) begin
      buffer <= buffer >> 8;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/stream_substring_replace_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                         Beat
// in        in_valid  in_ready  in_data     one byte and end-of-string mark
// out       out_valid out_ready out_data    one result byte, has_byte, last
// cfg       cfg_write cfg_index cfg_data    one register write, no wait
//
// One input beat is taken per cycle and results leave at one per cycle, unless held:
// a beat that causes several results holds the input while its burst drains, and a
// low out_ready holds both, since the output buffer takes the next burst only as
// its last byte leaves.
// The match itself is combinational in the cell row; a beat's burst is registered
// only in the output buffer. Synchronous reset clears the fill count, the buffer
// count and the configuration registers; the window bytes need no clearing.
module stream_substring_replace_unit #(
  parameter int MAX_PATTERN = 8,
  parameter int MAX_REPLACE = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ssr_pkg::ssr_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ssr_pkg::ssr_out_t      out_data,
  input  wire logic              cfg_write,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [63:0]       cfg_data
);

  localparam int FILL_W    = $clog2(MAX_PATTERN + 1);
  localparam int BUF_BYTES = (MAX_PATTERN > MAX_REPLACE) ? MAX_PATTERN : MAX_REPLACE;
  localparam int BUF_W     = 8 * BUF_BYTES;

  logic [8*MAX_PATTERN-1:0] pattern_bytes;
  logic [3:0]               pattern_length;
  logic [8*MAX_REPLACE-1:0] replacement_bytes;
  logic [3:0]               replacement_length;

  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [FILL_W-1:0] plen;
  logic [FILL_W-1:0] fill_eff;
  logic [FILL_W-1:0] fill_w;
  logic [3:0]        rlen;

  logic                     accept;
  logic                     do_win;
  logic                     full;
  logic                     match;
  logic [MAX_PATTERN-1:0]   hit;
  logic [MAX_PATTERN-1:0]   wr;
  logic [MAX_PATTERN-1:0]   active;
  logic [7:0]               cur [MAX_PATTERN];
  logic [8*MAX_PATTERN-1:0] win_vec;

  ssr_pkg::ssr_load_t load_ctl;
  logic [BUF_W-1:0]   load_data;

  // Clamp the configured lengths
  assign plen = (pattern_length > 4'(MAX_PATTERN)) ? FILL_W'(MAX_PATTERN)
                                                    : pattern_length[FILL_W-1:0];
  assign rlen = (replacement_length > 4'(MAX_REPLACE)) ? 4'(MAX_REPLACE)
                                                        : replacement_length;

  assign accept   = in_valid && in_ready;
  assign do_win   = (plen != '0);
  assign fill_eff = (fill >= plen) ? '0 : fill;
  assign fill_w   = fill_eff + FILL_W'(1);
  assign full     = (fill_w == plen);
  assign match    = &hit;

  // Row of window cells, oldest byte in cell 0
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic [7:0] next_in;

    assign wr[i]     = accept && do_win && (fill_eff == FILL_W'(i));
    assign active[i] = (FILL_W'(i) < plen);
    assign win_vec[8*i +: 8] = cur[i];

    if (i == MAX_PATTERN - 1) begin : g_end
      assign next_in = cur[i];
    end else begin : g_mid
      assign next_in = cur[i+1];
    end

    ssr_cell u_cell (
      .clk      (clk),
      .pat_byte (pattern_bytes[8*i +: 8]),
      .active   (active[i]),
      .wr       (wr[i]),
      .shift    (accept && do_win && full && !match),
      .in_byte  (in_data.in_byte),
      .next_in  (next_in),
      .cur      (cur[i]),
      .hit      (hit[i])
    );
  end

  // Work out the burst and the next fill count for this beat
  always_comb begin
    load_ctl.has_byte = 1'b1;
    load_ctl.last     = in_data.end_of_string;
    load_ctl.count    = '0;
    load_data         = BUF_W'(win_vec);
    fill_next         = '0;
    if (!do_win) begin
      load_ctl.count = ssr_pkg::CNT_W'(1);
      load_data      = BUF_W'(in_data.in_byte);
    end else if (full && match) begin
      load_ctl.count = ssr_pkg::CNT_W'(rlen);
      load_data      = BUF_W'(replacement_bytes);
    end else if (full) begin
      load_ctl.count = in_data.end_of_string ? ssr_pkg::CNT_W'(plen)
                                             : ssr_pkg::CNT_W'(1);
      fill_next      = in_data.end_of_string ? '0 : (plen - FILL_W'(1));
    end else begin
      load_ctl.count = in_data.end_of_string ? ssr_pkg::CNT_W'(fill_w) : '0;
      fill_next      = in_data.end_of_string ? '0 : fill_w;
    end
    // Mark an end of string that carries no byte
    if (in_data.end_of_string && (load_ctl.count == '0)) begin
      load_ctl.count    = ssr_pkg::CNT_W'(1);
      load_ctl.has_byte = 1'b0;
      load_data         = '0;
    end
  end

  // Fill count; a pattern length write empties the window
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cfg_write && (cfg_index == ssr_pkg::REG_PATTERN_LENGTH)) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= '0;
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        ssr_pkg::REG_PATTERN_BYTES: begin
          pattern_bytes <= cfg_data[8*MAX_PATTERN-1:0];
        end
        ssr_pkg::REG_PATTERN_LENGTH: begin
          pattern_length <= cfg_data[3:0];
        end
        ssr_pkg::REG_REPLACEMENT_BYTES: begin
          replacement_bytes <= cfg_data[8*MAX_REPLACE-1:0];
        end
        ssr_pkg::REG_REPLACEMENT_LENGTH: begin
          replacement_length <= cfg_data[3:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Output buffer
  ssr_burst #(
    .BYTES (BUF_BYTES)
  ) u_burst (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .load_ctl  (load_ctl),
    .load_data (load_data),
    .ready     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_fill_below_len: assert property (@(posedge clk) disable iff (rst)
    do_win |-> (fill < plen))
    else $error("window fill reached pattern length");

  a_pass_fill_zero: assert property (@(posedge clk) disable iff (rst)
    !do_win |-> (fill == '0))
    else $error("window holds bytes in pass-through mode");

  a_eos_flush: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.end_of_string) |=> (fill == '0))
    else $error("window not flushed after end of string");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.has_byte) |-> out_data.last)
    else $error("empty result beat without last");
`endif

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_PATTERN = 8;
  localparam int MAX_REPLACE = 8;
  localparam int HOLDOFF = 4;
  localparam int QUIET_LIMIT = 3000;
  localparam int SEG_ITEMS = 42;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  ssr_pkg::ssr_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ssr_pkg::ssr_out_t out_data;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = ssr_pkg::REG_PATTERN_BYTES;
  logic [63:0] cfg_data = '0;

  stream_substring_replace_unit #(
    .MAX_PATTERN(MAX_PATTERN),
    .MAX_REPLACE(MAX_REPLACE)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow copy of the rewrite state
  logic [63:0] pat_bytes = '0;
  logic [3:0] pat_len = '0;
  logic [63:0] rep_bytes = '0;
  logic [3:0] rep_len = '0;
  logic [7:0] window [8];
  int unsigned win_fill = 0;

  ssr_pkg::ssr_out_t expected_chars[$];
  ssr_pkg::ssr_out_t want_char;

  int errors = 0;
  int items_sent = 0;
  int chars_checked = 0;
  int regs_written = 0;
  int pattern_hits = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  function automatic int unsigned capped(logic [3:0] n, int unsigned cap);
    return (n > cap) ? cap : n;
  endfunction

  function automatic void emit_char(logic [7:0] b);
    expected_chars.push_back(ssr_pkg::ssr_out_t'{out_byte: b, has_byte: 1'b1, last: 1'b0});
  endfunction

  // Advance the window by one input char and queue the chars it releases
  function automatic void rewrite_byte(logic [7:0] b, logic eos);
    int unsigned plen;
    int unsigned base;
    bit hit;
    plen = capped(pat_len, MAX_PATTERN);
    base = expected_chars.size();
    if (plen == 0) begin
      win_fill = 0;
      emit_char(b);
    end else begin
      if (win_fill >= plen) win_fill = 0;
      window[win_fill] = b;
      win_fill++;
      if (win_fill == plen) begin
        hit = 1'b1;
        for (int i = 0; i < plen; i++) begin
          if (window[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          pattern_hits++;
          for (int i = 0; i < capped(rep_len, MAX_REPLACE); i++)
            emit_char(rep_bytes[8*i +: 8]);
          win_fill = 0;
        end else begin
          emit_char(window[0]);
          for (int i = 0; i < 7; i++) window[i] = window[i+1];
          win_fill--;
        end
      end
      // flush whatever the window still holds
      if (eos) begin
        for (int i = 0; i < win_fill; i++) emit_char(window[i]);
        win_fill = 0;
      end
    end
    if (eos) begin
      if (expected_chars.size() == base)
        expected_chars.push_back(ssr_pkg::ssr_out_t'{out_byte: 8'h00, has_byte: 1'b0,
                                                     last: 1'b0});
      expected_chars[expected_chars.size()-1].last = 1'b1;
    end
  endfunction

  // Drive one register write; the caller lowers cfg_write after the last one
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    regs_written++;
    case (idx)
      ssr_pkg::REG_PATTERN_BYTES: pat_bytes = val;
      ssr_pkg::REG_PATTERN_LENGTH: begin
        pat_len = val[3:0];
        win_fill = 0;
      end
      ssr_pkg::REG_REPLACEMENT_BYTES: rep_bytes = val;
      ssr_pkg::REG_REPLACEMENT_LENGTH: rep_len = val[3:0];
      default: ;
    endcase
  endtask

  // Send one input beat, optionally replacing the predicted burst with a known one
  task automatic send_char(ssr_pkg::ssr_in_t beat, bit known, ssr_pkg::ssr_out_t known_char);
    int gaps;
    int unsigned mark;
    gaps = 0;
    while ($urandom_range(99) < idle_pct) gaps++;
    if (gaps != 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
    mark = expected_chars.size();
    rewrite_byte(beat.in_byte, beat.end_of_string);
    if (known) begin
      while (expected_chars.size() > mark) void'(expected_chars.pop_back());
      expected_chars.push_back(known_char);
    end
    items_sent++;
  endtask

  // Hold the input until every expected char is out, then let the block settle
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (HOLDOFF) @(posedge clk);
  endtask

  // Directed script
  typedef struct {
    bit is_reg;
    logic [1:0] reg_index;
    logic [63:0] reg_value;
    ssr_pkg::ssr_in_t beat;
    bit known;
    ssr_pkg::ssr_out_t known_char;
  } script_row_t;

  script_row_t script[$];

  function automatic void add_reg(logic [1:0] idx, logic [63:0] val);
    script.push_back('{is_reg: 1'b1, reg_index: idx, reg_value: val,
                       beat: '0, known: 1'b0, known_char: '0});
  endfunction

  function automatic void add_char(logic [7:0] b, logic eos);
    script.push_back('{is_reg: 1'b0, reg_index: ssr_pkg::REG_PATTERN_BYTES, reg_value: '0,
                       beat: ssr_pkg::ssr_in_t'{in_byte: b, end_of_string: eos},
                       known: 1'b0, known_char: '0});
  endfunction

  function automatic void add_known(logic [7:0] b, logic eos, ssr_pkg::ssr_out_t c);
    script.push_back('{is_reg: 1'b0, reg_index: ssr_pkg::REG_PATTERN_BYTES, reg_value: '0,
                       beat: ssr_pkg::ssr_in_t'{in_byte: b, end_of_string: eos},
                       known: 1'b1, known_char: c});
  endfunction

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected result: out_byte %h has_byte %b last %b",
               out_data.out_byte, out_data.has_byte, out_data.last);
        errors++;
      end else begin
        want_char = expected_chars.pop_front();
        chars_checked++;
        if (out_data.out_byte !== want_char.out_byte) begin
          $error("out_byte: expected %h, got %h", want_char.out_byte, out_data.out_byte);
          errors++;
        end
        if (out_data.has_byte !== want_char.has_byte) begin
          $error("has_byte: expected %b, got %b", want_char.has_byte, out_data.has_byte);
          errors++;
        end
        if (out_data.last !== want_char.last) begin
          $error("last: expected %b, got %b", want_char.last, out_data.last);
          errors++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Stop a hung run
  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  int seg_plen [8] = '{2, 1, 8, 0, 3, 15, 5, 4};
  int seg_rlen [8] = '{3, 8, 0, 2, 15, 1, 7, 0};
  int phase_idle [4] = '{0, 55, 0, 38};
  int phase_stall [4] = '{0, 0, 55, 38};

  initial begin
    bit prev_reg;
    logic [7:0] letter_a;
    logic [7:0] letter_b;
    logic [63:0] pb;
    logic [63:0] rb;
    logic [7:0] text_q[$];
    int unsigned eff_len;
    int hold_at;
    ssr_pkg::ssr_in_t beat;

    // Known answers after reset: pass-through, one char per beat
    add_known(8'h00, 1'b0, ssr_pkg::ssr_out_t'{out_byte: 8'h00, has_byte: 1'b1, last: 1'b0});
    add_known(8'hFF, 1'b1, ssr_pkg::ssr_out_t'{out_byte: 8'hFF, has_byte: 1'b1, last: 1'b1});

    // "ab" -> "XYZ": plain hit, hit after a miss, flush of a partial window
    add_reg(ssr_pkg::REG_PATTERN_BYTES, 64'h6261);
    add_reg(ssr_pkg::REG_PATTERN_LENGTH, 64'd2);
    add_reg(ssr_pkg::REG_REPLACEMENT_BYTES, 64'h5A5958);
    add_reg(ssr_pkg::REG_REPLACEMENT_LENGTH, 64'd3);
    add_char("a", 1'b0);
    add_char("b", 1'b0);
    add_char("a", 1'b0);
    add_char("a", 1'b0);
    add_char("b", 1'b0);
    add_char("c", 1'b1);
    add_char("x", 1'b0);
    add_char("a", 1'b1);

    // Deleting replacement; hit on the final beat leaves an empty end marker
    add_reg(ssr_pkg::REG_REPLACEMENT_LENGTH, 64'd0);
    add_char("a", 1'b0);
    add_known("b", 1'b1, ssr_pkg::ssr_out_t'{out_byte: 8'h00, has_byte: 1'b0, last: 1'b1});

    // Oversized lengths clamp to eight; full-width hit gives the longest burst
    add_reg(ssr_pkg::REG_PATTERN_BYTES, '1);
    add_reg(ssr_pkg::REG_PATTERN_LENGTH, 64'd15);
    add_reg(ssr_pkg::REG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF);
    add_reg(ssr_pkg::REG_REPLACEMENT_LENGTH, 64'd15);
    for (int i = 0; i < 7; i++) add_char(8'hFF, 1'b0);
    add_char(8'hFF, 1'b1);

    // Single-char pattern: one char grows into eight
    add_reg(ssr_pkg::REG_PATTERN_BYTES, 64'd0);
    add_reg(ssr_pkg::REG_PATTERN_LENGTH, 64'd1);
    add_char(8'h00, 1'b0);
    add_char(8'h80, 1'b1);

    // Pattern rewrite mid-string drops the held chars
    add_reg(ssr_pkg::REG_PATTERN_BYTES, 64'h636261);
    add_reg(ssr_pkg::REG_PATTERN_LENGTH, 64'd3);
    add_char("a", 1'b0);
    add_char("b", 1'b0);
    add_reg(ssr_pkg::REG_PATTERN_LENGTH, 64'd3);
    add_reg(ssr_pkg::REG_REPLACEMENT_BYTES, '1);
    add_char("c", 1'b1);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed script
    idle_pct = 25;
    stall_pct = 25;
    prev_reg = 1'b0;
    foreach (script[i]) begin
      if (script[i].is_reg) begin
        if (!prev_reg) settle();
        write_reg(script[i].reg_index, script[i].reg_value);
        prev_reg = 1'b1;
      end else begin
        if (prev_reg) cfg_write <= 1'b0;
        send_char(script[i].beat, script[i].known, script[i].known_char);
        prev_reg = 1'b0;
      end
    end
    if (prev_reg) cfg_write <= 1'b0;

    // Random segments: two settings per idle/stall mix
    for (int seg = 0; seg < 8; seg++) begin
      idle_pct = phase_idle[seg/2];
      stall_pct = phase_stall[seg/2];
      letter_a = 8'($urandom_range(255));
      letter_b = 8'($urandom_range(255));
      for (int i = 0; i < 8; i++) pb[8*i +: 8] = $urandom_range(1) ? letter_a : letter_b;
      rb = (seg == 1) ? '1 : {$urandom, $urandom};
      settle();
      write_reg(ssr_pkg::REG_PATTERN_BYTES, pb);
      write_reg(ssr_pkg::REG_PATTERN_LENGTH, 64'(seg_plen[seg]));
      write_reg(ssr_pkg::REG_REPLACEMENT_BYTES, rb);
      write_reg(ssr_pkg::REG_REPLACEMENT_LENGTH, 64'(seg_rlen[seg]));
      cfg_write <= 1'b0;
      eff_len = capped(4'(seg_plen[seg]), MAX_PATTERN);
      text_q.delete();
      hold_at = $urandom_range(10, 35);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if (n == hold_at) settle();
        // whole patterns most often, some lone pattern chars, some noise
        if (text_q.size() == 0) begin
          case ($urandom_range(9))
            0, 1, 2, 3: begin
              if (eff_len == 0) text_q.push_back(8'($urandom_range(255)));
              for (int i = 0; i < eff_len; i++) text_q.push_back(pb[8*i +: 8]);
            end
            4, 5, 6: text_q.push_back($urandom_range(1) ? letter_a : letter_b);
            default: text_q.push_back(8'($urandom_range(255)));
          endcase
        end
        beat.in_byte = text_q.pop_front();
        beat.end_of_string = ($urandom_range(11) == 0);
        send_char(beat, 1'b0, '0);
      end
    end

    settle();
    $display("Sent %0d input chars, checked %0d output beats, %0d pattern hits.",
             items_sent, chars_checked, pattern_hits);
    $display("Used %0d register writes across pattern lengths 0 to 15 %s",
             regs_written, "and four idle/stall mixes.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- stream_substring_replace_unit.f -----
rtl/core/ssr_pkg.sv
rtl/core/ssr_cell.sv
rtl/core/ssr_burst.sv
rtl/core/stream_substring_replace_unit.sv
test/tb_top.sv
